>>> sv/pbr_pkg.sv
// Shared types and constants of the block receiver.
`timescale 1ns / 1ps

package pbr_pkg;

    // Command codes on the request side
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_ABORT = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    // Block layout and limits
    localparam logic [7:0]  BLOCK_MAX     = 8'd255;
    localparam logic [7:0]  MIN_LENGTH    = 8'd7;
    localparam logic [7:0]  SUM_START     = 8'd4;
    localparam logic [7:0]  PAYLOAD_START = 8'd7;
    localparam logic [15:0] FINAL_INDEX   = 16'hFF00;

    // Header byte offsets
    localparam logic [7:0] OFS_ADD_LO  = 8'd0;
    localparam logic [7:0] OFS_ADD_HI  = 8'd1;
    localparam logic [7:0] OFS_CYC_LO  = 8'd2;
    localparam logic [7:0] OFS_CYC_HI  = 8'd3;
    localparam logic [7:0] OFS_NEXT    = 8'd4;
    localparam logic [7:0] OFS_IDX_LO  = 8'd5;
    localparam logic [7:0] OFS_IDX_HI  = 8'd6;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [15:0] block_index;
        logic [7:0]  next_length;
        logic        transfer_done;
        logic        last;
    } t_result;

    // Classified operation held between front and back
    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_ABORT = 2'd1,
        OP_START = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_work;

    // Up to two results written per processed request
    typedef struct packed {
        logic    wr0;
        logic    wr1;
        t_result res0;
        t_result res1;
    } t_res_write;

    function automatic logic [7:0] clamp_length(input logic [7:0] len);
        logic [7:0] v;
        v = len;
        if (v < MIN_LENGTH) v = MIN_LENGTH;
        if (v > BLOCK_MAX) v = BLOCK_MAX;
        return v;
    endfunction

endpackage

>>> sv/pbr_front.sv
// Front end: accepts requests, classifies commands, queues them for the back end.
`timescale 1ns / 1ps

module pbr_front #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  pbr_pkg::t_request i_request,
    output pbr_pkg::t_work    o_work,
    input  logic              i_take
);
    import pbr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            accept;
    logic            keep;
    logic            pop_fire;
    t_item           cls;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) return '0;
        return p + AW'(1);
    endfunction

    // Classify; the unused command code is dropped here
    always_comb begin
        cls.data_byte = i_request.data_byte;
        keep          = 1'b1;
        unique case (i_request.command)
            CMD_DATA:  cls.op = OP_DATA;
            CMD_ABORT: cls.op = OP_ABORT;
            CMD_START: cls.op = OP_START;
            default: begin
                cls.op = OP_DATA;
                keep   = 1'b0;
            end
        endcase
    end

    assign o_full   = (r_count == CW'(DEPTH));
    assign accept   = i_push && !o_full && keep;
    assign pop_fire = i_take && (r_count != '0);

    assign o_work.valid = (r_count != '0);
    assign o_work.item  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = accept ? bump(r_wptr) : r_wptr;
        n_rptr  = pop_fire ? bump(r_rptr) : r_rptr;
        n_count = r_count + CW'(accept) - CW'(pop_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wptr] <= cls;
        end
    end

endmodule

>>> sv/pbr_back.sv
// Back end: block framing, running checksums and verdicts.
`timescale 1ns / 1ps

module pbr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbr_pkg::t_work      i_work,
    output logic                o_take,
    input  logic                i_space_ok,
    output pbr_pkg::t_res_write o_wr
);
    import pbr_pkg::*;

    logic [7:0]  r_expected, n_expected;
    logic [7:0]  r_position, n_position;
    logic [15:0] r_sum_add, n_sum_add;
    logic [15:0] r_sum_cyc, n_sum_cyc;
    logic [15:0] r_stored_add, n_stored_add;
    logic [15:0] r_stored_cyc, n_stored_cyc;
    logic [7:0]  r_hdr_next, n_hdr_next;
    logic [15:0] r_hdr_index, n_hdr_index;
    logic        r_receiving, n_receiving;

    logic [7:0]  b;
    logic [15:0] add_new;
    logic [15:0] cyc_xor;
    logic [15:0] cyc_new;
    logic [8:0]  pos_inc;
    logic        is_payload;
    logic        verdict;
    logic        good;
    logic        done;
    t_result     pay_res;
    t_result     ver_res;

    assign o_take = i_work.valid && i_space_ok;
    assign b      = i_work.item.data_byte;

    always_comb begin
        n_expected   = r_expected;
        n_position   = r_position;
        n_sum_add    = r_sum_add;
        n_sum_cyc    = r_sum_cyc;
        n_stored_add = r_stored_add;
        n_stored_cyc = r_stored_cyc;
        n_hdr_next   = r_hdr_next;
        n_hdr_index  = r_hdr_index;
        n_receiving  = r_receiving;
        o_wr.wr0     = 1'b0;
        o_wr.wr1     = 1'b0;

        // Header capture at the fixed offsets
        unique case (r_position)
            OFS_ADD_LO: n_stored_add = {r_stored_add[15:8], b};
            OFS_ADD_HI: n_stored_add = {b, r_stored_add[7:0]};
            OFS_CYC_LO: n_stored_cyc = {r_stored_cyc[15:8], b};
            OFS_CYC_HI: n_stored_cyc = {b, r_stored_cyc[7:0]};
            OFS_NEXT:   n_hdr_next   = b;
            OFS_IDX_LO: n_hdr_index  = {r_hdr_index[15:8], b};
            OFS_IDX_HI: n_hdr_index  = {b, r_hdr_index[7:0]};
            default:    ;
        endcase

        // Running sums over offset 4 onward: add, and xor then rotate left
        cyc_xor = r_sum_cyc ^ {8'h00, b};
        if (r_position >= SUM_START) begin
            add_new = r_sum_add + {8'h00, b};
            cyc_new = {cyc_xor[14:0], cyc_xor[15]};
        end else begin
            add_new = r_sum_add;
            cyc_new = r_sum_cyc;
        end

        pos_inc    = {1'b0, r_position} + 9'd1;
        is_payload = (r_position >= PAYLOAD_START);
        verdict    = (pos_inc >= {1'b0, r_expected});
        good       = (add_new == n_stored_add) && (cyc_new == n_stored_cyc);
        done       = good && ((n_hdr_index >= FINAL_INDEX) || (n_hdr_next < MIN_LENGTH));

        pay_res               = '0;
        pay_res.kind          = KIND_PAYLOAD;
        pay_res.payload       = b;
        pay_res.last          = !verdict;

        ver_res               = '0;
        ver_res.kind          = good ? KIND_GOOD : KIND_BAD;
        ver_res.block_index   = n_hdr_index;
        ver_res.next_length   = n_hdr_next;
        ver_res.transfer_done = done;
        ver_res.last          = 1'b1;

        o_wr.res0 = is_payload ? pay_res : ver_res;
        o_wr.res1 = ver_res;

        if (o_take) begin
            unique case (i_work.item.op)
                OP_START: begin
                    n_position   = '0;
                    n_sum_add    = '0;
                    n_sum_cyc    = '0;
                    n_stored_add = '0;
                    n_stored_cyc = '0;
                    n_hdr_next   = '0;
                    n_hdr_index  = '0;
                    n_expected   = clamp_length(b);
                    n_receiving  = 1'b1;
                end
                OP_ABORT: begin
                    n_position   = '0;
                    n_sum_add    = '0;
                    n_sum_cyc    = '0;
                    n_stored_add = '0;
                    n_stored_cyc = '0;
                    n_hdr_next   = '0;
                    n_hdr_index  = '0;
                end
                OP_DATA: begin
                    if (!r_receiving) begin
                        // Drop data while idle: restore untouched state
                        n_stored_add = r_stored_add;
                        n_stored_cyc = r_stored_cyc;
                        n_hdr_next   = r_hdr_next;
                        n_hdr_index  = r_hdr_index;
                    end else begin
                        o_wr.wr0 = is_payload || verdict;
                        o_wr.wr1 = is_payload && verdict;
                        if (verdict) begin
                            n_position = '0;
                            n_sum_add  = '0;
                            n_sum_cyc  = '0;
                            if (good) begin
                                if (done) n_receiving = 1'b0;
                                else n_expected = clamp_length(n_hdr_next);
                            end
                        end else begin
                            n_position = pos_inc[7:0];
                            n_sum_add  = add_new;
                            n_sum_cyc  = cyc_new;
                        end
                    end
                end
                default: ;
            endcase
        end else begin
            // Hold header fields when nothing is processed
            n_stored_add = r_stored_add;
            n_stored_cyc = r_stored_cyc;
            n_hdr_next   = r_hdr_next;
            n_hdr_index  = r_hdr_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= MIN_LENGTH;
            r_position   <= '0;
            r_sum_add    <= '0;
            r_sum_cyc    <= '0;
            r_stored_add <= '0;
            r_stored_cyc <= '0;
            r_hdr_next   <= '0;
            r_hdr_index  <= '0;
            r_receiving  <= 1'b0;
        end else begin
            r_expected   <= n_expected;
            r_position   <= n_position;
            r_sum_add    <= n_sum_add;
            r_sum_cyc    <= n_sum_cyc;
            r_stored_add <= n_stored_add;
            r_stored_cyc <= n_stored_cyc;
            r_hdr_next   <= n_hdr_next;
            r_hdr_index  <= n_hdr_index;
            r_receiving  <= n_receiving;
        end
    end

endmodule

>>> sv/pbr_result_queue.sv
// Result queue: takes up to two results per cycle, hands out one per pop.
`timescale 1ns / 1ps

module pbr_result_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbr_pkg::t_res_write i_wr,
    output logic                o_space_ok,
    output logic                o_empty,
    input  logic                i_pop,
    output pbr_pkg::t_result    o_result
);
    import pbr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   wptr_1;
    logic [AW-1:0]   wptr_2;
    logic            pop_fire;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) return '0;
        return p + AW'(1);
    endfunction

    assign o_space_ok = (r_count <= CW'(DEPTH - 2));
    assign o_empty    = (r_count == '0);
    assign o_result   = r_mem[r_rptr];
    assign pop_fire   = i_pop && !o_empty;
    assign wptr_1     = bump(r_wptr);
    assign wptr_2     = bump(wptr_1);

    always_comb begin
        if (i_wr.wr1) n_wptr = wptr_2;
        else if (i_wr.wr0) n_wptr = wptr_1;
        else n_wptr = r_wptr;
        n_rptr  = pop_fire ? bump(r_rptr) : r_rptr;
        n_count = r_count + CW'(i_wr.wr0) + CW'(i_wr.wr1) - CW'(pop_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr0) begin
            r_mem[r_wptr] <= i_wr.res0;
        end
        if (i_wr.wr1) begin
            r_mem[wptr_1] <= i_wr.res1;
        end
    end

endmodule

>>> sv/punter_block_receiver_core.sv
// Top level of the byte-serial checksummed block receiver.
`timescale 1ns / 1ps

// Byte-serial receiver for checksummed transfer blocks. Push one request per
// cycle: a data byte, an abort of the partial block, or a start that sets the
// first block length (raised to 7 when below). Each block carries two stored
// 16-bit checksums, a next-block length, a 16-bit index and a payload; payload
// bytes come out tentatively as they arrive, and the last byte of a block also
// yields a good or bad verdict, so that byte produces two results when it is a
// payload byte. Requests are taken at one per cycle: the checksum unit takes
// the next one whenever the result queue has room for two results. A block of
// length L yields at most L-6 results, so with the default RQ_DEPTH a consumer
// that pops every cycle never holds up the request side; only stalls on the
// result side fill the queues, and full rises once IQ_DEPTH requests are
// waiting. A result enters the result queue register when the back end takes
// its request from the request queue, which it does only while there is room.
module punter_block_receiver_core #(
    parameter int IQ_DEPTH = 4,  // request queue entries, at least 2
    parameter int RQ_DEPTH = 4   // result queue entries, at least 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  pbr_pkg::t_request i_request,
    output logic              empty,
    input  logic              pop,
    output pbr_pkg::t_result  o_result
);
    import pbr_pkg::*;

    t_work      work;        // head of the request queue
    logic       take;        // back end consumes the head this cycle
    logic       space_ok;    // result queue can absorb two results
    t_res_write res_wr;      // results produced by the back end

    // Front: accept and classify requests, drop unused command codes
    pbr_front #(
        .DEPTH (IQ_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_request (i_request),
        .o_work    (work),
        .i_take    (take)
    );

    // Back: framing, checksums, verdicts; stalls while the result queue is short
    pbr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_work     (work),
        .o_take     (take),
        .i_space_ok (space_ok),
        .o_wr       (res_wr)
    );

    // Result queue: oldest result on the output while not empty
    pbr_result_queue #(
        .DEPTH (RQ_DEPTH)
    ) u_result_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (res_wr),
        .o_space_ok (space_ok),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule
